### src/trace_frame_writer_core_defines.svh
// Assertion macros shared by the trace frame writer RTL.
// Depends on nothing; included by the top level only.
`ifndef TRACE_FRAME_WRITER_CORE_DEFINES_SVH
`define TRACE_FRAME_WRITER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TFW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TFW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tfw_pkg.sv
// Shared types, codes, constants and check functions of the trace frame writer.
// Used by tfw_front, tfw_fifo, tfw_back and trace_frame_writer_core.
`timescale 1ns / 1ps

package tfw_pkg;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_WORD  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic CFG_MAGIC   = 1'b0;
  localparam logic CFG_VERSION = 1'b1;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
  localparam int          FNV_PRIME_SHIFT = 40;

  localparam logic [31:0] MAGIC_RST   = 32'h0000_0000;
  localparam logic [15:0] VERSION_RST = 16'h0001;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value_bits;
    logic [63:0] plan_id;
    logic [15:0] sig_cnt;
    logic [31:0] row_cnt;
  } cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // x * 0x100000001b3 mod 2^64
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    logic [72:0] p;
    p = x * FNV_PRIME_LO;
    return (x << FNV_PRIME_SHIFT) + p[63:0];
  endfunction

endpackage

### src/tfw_front.sv
// Input side: accepts stream transfers, drops unused operation codes and
// packs commands for the queue. Depends on tfw_pkg.
`timescale 1ns / 1ps

module tfw_front (
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [143:0]    in_tdata,   // value_bits, plan_id, sig_cnt, row_cnt
  input  logic [1:0]      in_tuser,   // operation
  input  logic            q_full,
  output logic            q_push,
  output tfw_pkg::cmd_t   q_cmd
);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && (in_tuser != tfw_pkg::OP_NONE);

  always_comb begin
    q_cmd.kind       = in_tuser;
    q_cmd.value_bits = in_tdata[31:0];
    q_cmd.plan_id    = in_tdata[95:32];
    q_cmd.sig_cnt    = in_tdata[111:96];
    q_cmd.row_cnt    = in_tdata[143:112];
  end

endmodule

### src/tfw_fifo.sv
// Short command queue between the front and the back end.
// Depends on tfw_pkg for the command type.
`timescale 1ns / 1ps

module tfw_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tfw_pkg::cmd_t   din,
  input  logic            pop,
  output tfw_pkg::cmd_t   dout,
  output logic            full,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tfw_pkg::cmd_t  mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

### src/tfw_back.sv
// Back end: runs one command at a time, byte-serial CRC-32 and FNV-1a-64,
// header build and word emission through an output register. Depends on tfw_pkg.
`timescale 1ns / 1ps

module tfw_back (
  input  logic            clk,
  input  logic            rst_n,
  input  tfw_pkg::cmd_t   cmd,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  input  logic [31:0]     magic,
  input  logic [15:0]     version,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,  // output_word
  output logic            out_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LEN  = 3'd1;
  localparam logic [2:0] ST_HCRC = 3'd2;
  localparam logic [2:0] ST_WORD = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [63:0] fnv_r, fnv_nxt;
  logic [31:0] hcrc_r, hcrc_nxt;
  logic [31:0] w_r [8];
  logic [31:0] w_nxt [8];
  logic [4:0]  cnt_r, cnt_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [2:0]  last_idx_r, last_idx_nxt;
  logic        emitted_r, emitted_nxt;

  logic        slot_free;
  logic [7:0]  byte_sel;
  logic [31:0] hcrc_step;
  logic [31:0] len_prod;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign slot_free = !out_valid_r || out_tready;
  assign byte_sel  = 8'(w_r[0] >> {cnt_r[1:0], 3'b000});
  assign hcrc_step = tfw_pkg::crc_byte(hcrc_r, byte_sel);
  assign len_prod  = w_r[2] * ({16'd0, w_r[1][31:16]} + 32'd1);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    crc_nxt       = crc_r;
    fnv_nxt       = fnv_r;
    hcrc_nxt      = hcrc_r;
    w_nxt         = w_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    last_idx_nxt  = last_idx_r;
    emitted_nxt   = emitted_r;
    cmd_pop       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            tfw_pkg::OP_BEGIN: begin
              w_nxt[0]  = magic;
              w_nxt[1]  = {cmd.sig_cnt, version};
              w_nxt[2]  = cmd.row_cnt;
              w_nxt[3]  = cmd.plan_id[31:0];
              w_nxt[4]  = cmd.plan_id[63:32];
              w_nxt[7]  = '0;
              crc_nxt   = tfw_pkg::CRC_INIT;
              fnv_nxt   = tfw_pkg::FNV_BASIS;
              state_nxt = ST_LEN;
            end
            tfw_pkg::OP_WORD: begin
              w_nxt[0]    = cmd.value_bits;
              cnt_nxt     = '0;
              emitted_nxt = 1'b0;
              state_nxt   = ST_WORD;
            end
            tfw_pkg::OP_END: begin
              w_nxt[0]     = ~crc_r;
              w_nxt[1]     = fnv_r[31:0];
              w_nxt[2]     = fnv_r[63:32];
              idx_nxt      = '0;
              last_idx_nxt = 3'd2;
              state_nxt    = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LEN: begin
        w_nxt[5]  = {len_prod[29:0], 2'b00};
        hcrc_nxt  = tfw_pkg::CRC_INIT;
        cnt_nxt   = '0;
        state_nxt = ST_HCRC;
      end
      ST_HCRC: begin
        // header words 0..5 rotate through slot 0, one byte per cycle
        hcrc_nxt = hcrc_step;
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r[1:0] == 2'd3) begin
          for (int i = 0; i < 5; i++) begin
            w_nxt[i] = w_r[i+1];
          end
          w_nxt[5] = w_r[0];
        end
        if (cnt_r == 5'd23) begin
          w_nxt[6]     = ~hcrc_step;
          idx_nxt      = '0;
          last_idx_nxt = 3'd7;
          state_nxt    = ST_EMIT;
        end
      end
      ST_WORD: begin
        if (!cnt_r[2]) begin
          crc_nxt = tfw_pkg::crc_byte(crc_r, byte_sel);
          fnv_nxt = tfw_pkg::fnv_mul(fnv_r ^ {56'h0, byte_sel});
          cnt_nxt = cnt_r + 5'd1;
        end
        if (slot_free && !emitted_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = w_r[0];
          out_last_nxt  = 1'b1;
          emitted_nxt   = 1'b1;
        end
        if (cnt_nxt[2] && emitted_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = w_r[0];
          out_last_nxt  = (idx_r == last_idx_r);
          for (int i = 0; i < 7; i++) begin
            w_nxt[i] = w_r[i+1];
          end
          idx_nxt = idx_r + 3'd1;
          if (idx_r == last_idx_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      crc_r       <= tfw_pkg::CRC_INIT;
      fnv_r       <= tfw_pkg::FNV_BASIS;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      crc_r       <= crc_nxt;
      fnv_r       <= fnv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    hcrc_r     <= hcrc_nxt;
    w_r        <= w_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    emitted_r  <= emitted_nxt;
  end

endmodule

### src/trace_frame_writer_core.sv
// Word item: four CRC/FNV byte steps in the back end, run while the word is emitted.
// Begin item: 1 length multiply, 24 header CRC bytes, 8 emitted words.
// End item: three trailer words. The queue takes items while the back end runs.
// Reset: rst_n synchronous, active low; clears queue and output valid, sets the checks
// to their initial values, and loads magic 0, version 1.
`timescale 1ns / 1ps
`include "trace_frame_writer_core_defines.svh"

module trace_frame_writer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [143:0]  in_tdata,   // value_bits, plan_id, sig_cnt, row_cnt
  input  logic [1:0]    in_tuser,   // operation
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata,  // output_word
  output logic          out_tlast,  // last_word
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_wdata
);

  logic [31:0]    magic_r;
  logic [15:0]    version_r;
  logic           q_push, q_pop, q_full, q_empty;
  logic           op_taken;
  tfw_pkg::cmd_t  q_in, q_out;

  assign op_taken = in_tvalid && in_tready && (in_tuser != tfw_pkg::OP_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= tfw_pkg::MAGIC_RST;
      version_r <= tfw_pkg::VERSION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tfw_pkg::CFG_MAGIC:   magic_r   <= cfg_wdata;
        tfw_pkg::CFG_VERSION: version_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  tfw_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  tfw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  tfw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (q_out),
    .cmd_valid  (!q_empty),
    .cmd_pop    (q_pop),
    .magic      (magic_r),
    .version    (version_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `TFW_ASSERT_IMP(a_push_room, clk, rst_n, q_push, !q_full, "push into full queue")
  `TFW_ASSERT_IMP(a_pop_data, clk, rst_n, q_pop, !q_empty, "pop from empty queue")
  `TFW_ASSERT_IMP(a_op_queued, clk, rst_n, op_taken, q_push, "accepted op not queued")
  `TFW_ASSERT_NXT(a_push_lands, clk, rst_n, q_push && !q_pop, !q_empty, "queue empty after push")

endmodule
